/* hw/rtl/bca_pkg.sv */
// Shared types and constants for the block chain allocator.
// No dependencies; imported by block_chain_allocator_top.
`timescale 1ns / 1ps

package bca_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int BLK_AW     = $clog2(MAX_BLOCKS);

    // Block header flags
    localparam logic [1:0] FLAG_FREE    = 2'h1;
    localparam logic [1:0] FLAG_CHAINED = 2'h2;
    localparam logic [1:0] FLAG_USED    = 2'h0;

    // Register map (index = paddr[2])
    localparam logic REG_BLOCK_BYTES = 1'b0;
    localparam logic REG_BLOCK_TOTAL = 1'b1;

    localparam logic [12:0] BLOCK_BYTES_RST = 13'd32;
    localparam logic [6:0]  BLOCK_TOTAL_RST = 7'd64;
    localparam logic [18:0] POOL_BYTES_MAX  = 19'h7FFFF;

    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_REINIT = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SIZE   = 3'd1,
        ST_ROOM   = 3'd2,
        ST_HANDLE = 3'd3,
        ST_RANGE  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_WALK,
        S_RETRACT
    } t_state;

endpackage

/* hw/rtl/block_chain_allocator_top.sv */
// Block chain allocator: header memory, allocate / free / reinitialise sequencer.
// Depends on bca_pkg.
`timescale 1ns / 1ps
//
//  Channel    Signals                                         Handshake
//  --------   ---------------------------------------------   ---------------------------
//  command    start, i_mode, i_alloc_bytes, i_start_index,    taken when start && !busy
//             i_handle_ok
//  result     o_done, o_status, o_first_block,                o_done one cycle, no stall
//             o_pool_bytes, o_top_index
//  config     psel, penable, pwrite, paddr, pwdata, prdata,   APB write on access cycle
//             pready
//
//  Errors, reinitialise and the unused mode finish in the accept cycle, with the result
//  strobed on the next one. Allocate writes one header per block handed out (1..64); the
//  block count falls out of repeated subtraction of the block payload. Free walks the
//  chain block by block, then retracts trailing free blocks below top; the single read
//  port of the header memory, read one block ahead, sets the pace of both walks.
//  Reset clears header valid bits (blocks read free) and top; config gets reset values.
//  The receiver cannot stall; busy holds off new commands while allocate or free runs.

module block_chain_allocator_top
    import bca_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [19:0] i_alloc_bytes,
    input  logic [5:0]  i_start_index,
    input  logic        i_handle_ok,
    // result
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [5:0]  o_first_block,
    output logic [18:0] o_pool_bytes,
    output logic [6:0]  o_top_index,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [12:0] r_block_bytes;
    logic [6:0]  r_block_total;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BLOCK_BYTES_RST;
            r_block_total <= BLOCK_TOTAL_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_BLOCK_BYTES) begin
                r_block_bytes <= pwdata[12:0];
            end else begin
                r_block_total <= pwdata[6:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_BLOCK_TOTAL) begin
            prdata = {25'd0, r_block_total};
        end else begin
            prdata = {19'd0, r_block_bytes};
        end
    end

    // ------------------------------------------------------------------
    // Derived pool shape (read live)
    // ------------------------------------------------------------------
    logic [6:0]  n_blocks;      // min(block_total, MAX_BLOCKS)
    logic [6:0]  blocks_left;
    logic [12:0] pay_bytes;
    logic [19:0] room_bytes;
    logic [19:0] pool_prod;
    logic [18:0] pool_sat;

    assign n_blocks    = (r_block_total < 7'(MAX_BLOCKS)) ? r_block_total : 7'(MAX_BLOCKS);
    assign pay_bytes   = (r_block_bytes > 13'd1) ? (r_block_bytes - 13'd1) : 13'd0;
    assign pool_prod   = 20'(r_block_bytes) * 20'(n_blocks);
    assign pool_sat    = (pool_prod > 20'(POOL_BYTES_MAX)) ? POOL_BYTES_MAX : pool_prod[18:0];

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    t_state      r_state, n_state;
    logic [6:0]  r_top, n_top;
    logic [6:0]  r_ptr, n_ptr;
    logic [19:0] r_rem, n_rem;
    logic [12:0] r_pay, n_pay;
    logic [5:0]  r_first, n_first;

    // result register
    logic        r_done;
    t_status     r_status;
    logic [5:0]  r_first_out;
    logic [18:0] r_pool_out;
    logic [6:0]  r_top_out;

    // finish request from the sequencer
    logic        fin;
    t_status     fin_status;
    logic [5:0]  fin_first;
    logic [18:0] fin_pool;

    // header memory ports
    logic              wr_en;
    logic [BLK_AW-1:0] wr_addr;
    logic [1:0]        wr_data;
    logic [BLK_AW-1:0] rd_addr;
    logic [1:0]        r_rd_data;
    logic              r_rd_vld;
    logic              clr_valid;
    logic [1:0]        rd_flag;

    logic [1:0] r_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_valid;

    logic accept;
    logic last_blk;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign blocks_left = (r_top < n_blocks) ? (n_blocks - r_top) : 7'd0;
    assign room_bytes  = 20'(blocks_left) * 20'(pay_bytes);
    // entries never written since reset or reinitialise read as free
    assign rd_flag     = r_rd_vld ? r_rd_data : FLAG_FREE;
    assign last_blk    = (r_rem <= 20'(r_pay));

    // ------------------------------------------------------------------
    // Next state and datapath control
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_top      = r_top;
        n_ptr      = r_ptr;
        n_rem      = r_rem;
        n_pay      = r_pay;
        n_first    = r_first;
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_first  = 6'd0;
        fin_pool   = 19'd0;
        wr_en      = 1'b0;
        wr_addr    = r_ptr[BLK_AW-1:0];
        wr_data    = FLAG_FREE;
        rd_addr    = BLK_AW'(i_start_index);
        clr_valid  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_mode'(i_mode))
                        MODE_ALLOC: begin
                            if (i_alloc_bytes == 20'd0) begin
                                fin        = 1'b1;
                                fin_status = ST_SIZE;
                            end else if (i_alloc_bytes > room_bytes) begin
                                fin        = 1'b1;
                                fin_status = ST_ROOM;
                            end else begin
                                // hold the payload size so the block count stays bounded
                                n_rem   = i_alloc_bytes;
                                n_pay   = pay_bytes;
                                n_ptr   = r_top;
                                n_first = r_top[5:0];
                                n_state = S_ALLOC;
                            end
                        end
                        MODE_FREE: begin
                            if (!i_handle_ok) begin
                                fin        = 1'b1;
                                fin_status = ST_HANDLE;
                            end else if ({1'b0, i_start_index} >= n_blocks) begin
                                fin        = 1'b1;
                                fin_status = ST_RANGE;
                            end else begin
                                // first header read goes out with this accept
                                n_ptr   = {1'b0, i_start_index};
                                n_state = S_WALK;
                            end
                        end
                        MODE_REINIT: begin
                            fin = 1'b1;
                            if (r_block_bytes == 13'd0 || r_block_total == 7'd0) begin
                                fin_status = ST_RANGE;
                            end else begin
                                clr_valid = 1'b1;
                                n_top     = 7'd0;
                                fin_pool  = pool_sat;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_ALLOC: begin
                // one block per cycle; the last one drops its chain flag
                wr_en   = 1'b1;
                wr_data = last_blk ? FLAG_USED : FLAG_CHAINED;
                if (last_blk) begin
                    n_top     = r_ptr + 7'd1;
                    fin       = 1'b1;
                    fin_first = r_first;
                    n_state   = S_IDLE;
                end else begin
                    n_rem = r_rem - 20'(r_pay);
                    n_ptr = r_ptr + 7'd1;
                end
            end

            S_WALK: begin
                // rd_flag belongs to r_ptr; read the next block ahead
                wr_en = 1'b1;
                if (rd_flag[1] && ((r_ptr + 7'd1) < n_blocks)) begin
                    n_ptr   = r_ptr + 7'd1;
                    rd_addr = BLK_AW'(r_ptr + 7'd1);
                end else if ((r_ptr + 7'd1) == r_top) begin
                    // the block just freed sits below top: drop it without a read
                    n_top   = r_top - 7'd1;
                    rd_addr = BLK_AW'(r_top - 7'd2);
                    if (n_top == 7'd0) begin
                        fin     = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RETRACT;
                    end
                end else begin
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_RETRACT: begin
                // rd_flag belongs to r_top-1
                rd_addr = BLK_AW'(r_top - 7'd2);
                if (rd_flag[0]) begin
                    n_top = r_top - 7'd1;
                    if (n_top == 7'd0) begin
                        fin     = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Header memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[rd_addr];
            if (clr_valid) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= 7'd0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_done  <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_rem   <= n_rem;
        r_pay   <= n_pay;
        r_first <= n_first;
        if (fin) begin
            r_status    <= fin_status;
            r_first_out <= fin_first;
            r_pool_out  <= fin_pool;
            r_top_out   <= n_top;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_first_block = r_first_out;
    assign o_pool_bytes  = r_pool_out;
    assign o_top_index   = r_top_out;

`ifndef ASSERT_OFF
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= 7'(MAX_BLOCKS))
        else $error("top beyond pool");

    a_alloc_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |-> (r_ptr < 7'(MAX_BLOCKS)))
        else $error("allocate walked past the header memory");

    a_done_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("walk ended without a result");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobed while still busy");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for block_chain_allocator_top: drives allocate, free, reinit and
// unused-mode commands with random gaps and register changes, checks every result.
// Depends on bca_pkg and block_chain_allocator_top.

import bca_pkg::*;

typedef struct {
    t_status     status;
    logic [5:0]  first;
    logic [18:0] pool;
    logic [6:0]  top;
} pool_result_t;

// Tracks the header flags, top and registers of the pool, and holds the results that
// the accepted commands are due to produce, oldest first.
class chain_pool_scoreboard;
    bit [1:0]     hdr_flags [MAX_BLOCKS];
    int           top_blk;
    int           blk_bytes;
    int           blk_total;
    pool_result_t pending_results [$];
    int           mismatches;

    function new();
        blk_bytes  = int'(BLOCK_BYTES_RST);
        blk_total  = int'(BLOCK_TOTAL_RST);
        mismatches = 0;
        clear_pool();
    endfunction

    function void clear_pool();
        for (int i = 0; i < MAX_BLOCKS; i++) hdr_flags[i] = FLAG_FREE;
        top_blk = 0;
    endfunction

    function void write_register(logic idx, logic [31:0] value);
        if (idx == REG_BLOCK_BYTES) blk_bytes = int'(value[12:0]);
        else                        blk_total = int'(value[6:0]);
    endfunction

    function int pool_blocks();
        return (blk_total < MAX_BLOCKS) ? blk_total : MAX_BLOCKS;
    endfunction

    function int block_payload();
        return (blk_bytes > 1) ? blk_bytes - 1 : 0;
    endfunction

    function int payload_room();
        int n;
        n = pool_blocks();
        return ((top_blk < n) ? n - top_blk : 0) * block_payload();
    endfunction

    // Update the pool for one accepted command and queue the result it must give.
    function pool_result_t predict_command(t_mode m, logic [19:0] nbytes,
                                           logic [5:0] sidx, logic hok);
        pool_result_t r;
        int n;
        int pay;
        int blocks;
        int b;
        n        = pool_blocks();
        pay      = block_payload();
        r.status = ST_OK;
        r.first  = '0;
        r.pool   = '0;
        case (m)
            MODE_ALLOC: begin
                if (nbytes == 0) begin
                    r.status = ST_SIZE;
                end else if (int'(nbytes) > payload_room()) begin
                    r.status = ST_ROOM;
                end else begin
                    blocks = (int'(nbytes) + pay - 1) / pay;
                    for (b = top_blk; b < top_blk + blocks; b++)
                        if (b < MAX_BLOCKS) hdr_flags[b] = FLAG_CHAINED;
                    if (top_blk + blocks - 1 < MAX_BLOCKS)
                        hdr_flags[top_blk + blocks - 1] = FLAG_USED;
                    r.first = 6'(top_blk);
                    top_blk += blocks;
                end
            end
            MODE_FREE: begin
                if (!hok) begin
                    r.status = ST_HANDLE;
                end else if (int'(sidx) >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    // the walk never runs past the last block of the pool
                    b = int'(sidx);
                    while ((hdr_flags[b] & FLAG_CHAINED) != 0 && b + 1 < n) begin
                        hdr_flags[b] = FLAG_FREE;
                        b++;
                    end
                    hdr_flags[b] = FLAG_FREE;
                    if (b + 1 == top_blk)
                        while (top_blk > 0 && top_blk - 1 < MAX_BLOCKS &&
                               (hdr_flags[top_blk - 1] & FLAG_FREE) != 0)
                            top_blk--;
                end
            end
            MODE_REINIT: begin
                if (blk_bytes == 0 || blk_total == 0) begin
                    r.status = ST_RANGE;
                end else begin
                    clear_pool();
                    r.pool = (blk_bytes * n > POOL_BYTES_MAX) ? POOL_BYTES_MAX
                                                             : 19'(blk_bytes * n);
                end
            end
            default: ;
        endcase
        r.top = 7'(top_blk);
        pending_results.push_back(r);
        return r;
    endfunction

    task report(string msg);
        $display("[tb] %0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task check_result(logic [2:0] st, logic [5:0] fb, logic [18:0] pb, logic [6:0] ti);
        pool_result_t e;
        if (pending_results.size() == 0) begin
            report($sformatf("result with nothing pending: status=%0d top=%0d", st, ti));
            return;
        end
        e = pending_results.pop_front();
        if (st !== e.status)
            report($sformatf("status %0d, want %0d", st, e.status));
        if (fb !== e.first)
            report($sformatf("first_block %0d, want %0d", fb, e.first));
        if (pb !== e.pool)
            report($sformatf("pool_bytes %0d, want %0d", pb, e.pool));
        if (ti !== e.top)
            report($sformatf("top_index %0d, want %0d", ti, e.top));
    endtask
endclass

module testbench;

    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 200;
    // no gaps once this many random commands have gone in
    localparam int GAP_STOP_ITEM  = 1400;
    // sized for the longest item; a register change waits out the sequencer too
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_mode;
    logic [19:0] i_alloc_bytes;
    logic [5:0]  i_start_index;
    logic        i_handle_ok;
    logic        o_done;
    logic [2:0]  o_status;
    logic [5:0]  o_first_block;
    logic [18:0] o_pool_bytes;
    logic [6:0]  o_top_index;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    chain_pool_scoreboard sb = new();

    // start blocks of allocations that have not been freed by a matching free yet
    logic [5:0] live_handles [$];
    int         idle_cycles = 0;

    block_chain_allocator_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_alloc_bytes(i_alloc_bytes),
        .i_start_index(i_start_index),
        .i_handle_ok  (i_handle_ok),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_first_block(o_first_block),
        .o_pool_bytes (o_pool_bytes),
        .o_top_index  (o_top_index),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Results are strobed for one cycle and cannot be held off: grab every one at the
    // edge that closes its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_status, o_first_block, o_pool_bytes, o_top_index);
    end

    // Watchdog: any transaction on the command, result or register port restarts it.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[block_chain_allocator_top] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one command from the falling edge and hold it until the block takes it.
    // start stays high on return so back-to-back commands go in without a gap.
    task automatic issue(input t_mode m, input logic [19:0] nbytes, input logic [5:0] sidx,
                         input logic hok, output pool_result_t r);
        @(negedge i_clk);
        start         = 1'b1;
        i_mode        = m;
        i_alloc_bytes = nbytes;
        i_start_index = sidx;
        i_handle_ok   = hok;
        do @(posedge i_clk); while (busy);
        r = sb.predict_command(m, nbytes, sidx, hok);
    endtask

    task automatic pause(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // Registers change only with nothing in flight: drop start, let every pending
    // result come back and the sequencer fall idle.
    task automatic settle_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready. Upper data bits carry
    // noise, which the register must drop.
    task automatic write_register(input logic idx, input logic [12:0] value);
        logic [31:0] word;
        word = $urandom();
        if (idx == REG_BLOCK_BYTES) word[12:0] = value;
        else                        word[6:0]  = value[6:0];
        settle_idle();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = word;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_register(idx, word);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin
        pool_result_t r;
        int           item_no;
        int           pick;
        int           room;
        int           pay;
        int           slot;
        logic [19:0]  nbytes;
        logic [5:0]   sidx;
        logic         hok;
        logic [12:0]  cfg_bytes;
        logic [6:0]   cfg_total;

        // Hold every input at a known value from time zero.
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_mode        = MODE_ALLOC;
        i_alloc_bytes = '0;
        i_start_index = '0;
        i_handle_ok   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- Directed part, reset registers: 32-byte blocks, 64 blocks, 31 payload ----
        issue(MODE_NOP, 20'hFFFFF, 6'h3F, 1'b1, r);   // unused mode: no change, ok
        issue(MODE_ALLOC, 20'd0, 6'd0, 1'b0, r);      // zero request
        issue(MODE_ALLOC, 20'hFFFFF, 6'd0, 1'b0, r);  // far beyond the room
        issue(MODE_ALLOC, 20'd1, 6'd0, 1'b0, r);      // one block at 0
        issue(MODE_ALLOC, 20'd62, 6'd0, 1'b0, r);     // two blocks at 1
        issue(MODE_FREE, 20'd0, 6'd1, 1'b0, r);       // invalid handle
        issue(MODE_FREE, 20'd0, 6'd63, 1'b1, r);      // lone free block above top
        issue(MODE_ALLOC, 20'd1891, 6'd0, 1'b0, r);   // exactly the room left: 3..63
        issue(MODE_ALLOC, 20'd1, 6'd0, 1'b0, r);      // pool full
        issue(MODE_FREE, 20'd0, 6'd1, 1'b1, r);       // chain below top, no retract
        issue(MODE_FREE, 20'd0, 6'd3, 1'b1, r);       // chain ends at top: retract to 1
        issue(MODE_REINIT, 20'd0, 6'd0, 1'b0, r);
        issue(MODE_ALLOC, 20'd1860, 6'd0, 1'b0, r);   // sixty blocks

        // Shrink the pool under a live chain.
        write_register(REG_BLOCK_TOTAL, 13'd10);
        issue(MODE_FREE, 20'd0, 6'd20, 1'b1, r);      // start beyond the pool
        issue(MODE_ALLOC, 20'd1, 6'd0, 1'b0, r);      // top above the pool: no room
        issue(MODE_FREE, 20'd0, 6'd0, 1'b1, r);       // runaway chain stops at block 9

        write_register(REG_BLOCK_BYTES, 13'd0);
        issue(MODE_REINIT, 20'd0, 6'd0, 1'b0, r);     // bad pool shape
        issue(MODE_ALLOC, 20'd5, 6'd0, 1'b0, r);      // no payload per block
        write_register(REG_BLOCK_BYTES, 13'd1);
        issue(MODE_ALLOC, 20'd1, 6'd0, 1'b0, r);      // header only, still no payload

        write_register(REG_BLOCK_BYTES, 13'h1FFF);
        write_register(REG_BLOCK_TOTAL, 13'd0);
        issue(MODE_REINIT, 20'd0, 6'd0, 1'b0, r);     // empty pool is a bad shape
        issue(MODE_FREE, 20'd0, 6'd0, 1'b1, r);       // every start is out of range
        write_register(REG_BLOCK_TOTAL, 13'd127);     // clamps to MAX_BLOCKS
        issue(MODE_REINIT, 20'd0, 6'd0, 1'b0, r);     // largest pool size
        issue(MODE_ALLOC, 20'hFFFFF, 6'd0, 1'b0, r);
        issue(MODE_ALLOC, 20'd524160, 6'd0, 1'b0, r); // whole pool in one chain
        issue(MODE_FREE, 20'd0, 6'd0, 1'b1, r);       // free it all, top back to 0

        // ---- Random part: several register settings, mostly well-formed traffic ----
        item_no = 0;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case ($urandom_range(0, 8))
                0:       cfg_bytes = 13'd2;
                1:       cfg_bytes = 13'd3;
                2:       cfg_bytes = 13'd4096;
                3:       cfg_bytes = 13'h1FFF;
                4:       cfg_bytes = 13'($urandom_range(2, 4096));
                default: cfg_bytes = 13'($urandom_range(2, 300));
            endcase
            case ($urandom_range(0, 6))
                0:       cfg_total = 7'd1;
                1:       cfg_total = 7'd2;
                2:       cfg_total = 7'd64;
                3:       cfg_total = 7'd127;
                default: cfg_total = 7'($urandom_range(3, 63));
            endcase
            // the first phase goes back to the reset values, the last to tiny blocks
            if (phase == 0) begin
                cfg_bytes = BLOCK_BYTES_RST;
                cfg_total = BLOCK_TOTAL_RST;
            end else if (phase == RAND_PHASES - 1) begin
                cfg_bytes = 13'd2;
            end
            write_register(REG_BLOCK_BYTES, cfg_bytes);
            write_register(REG_BLOCK_TOTAL, {6'd0, cfg_total});
            live_handles.delete();
            issue(MODE_REINIT, 20'($urandom()), 6'($urandom()), 1'($urandom()), r);

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (item_no < GAP_STOP_ITEM && $urandom_range(0, 5) == 0)
                    pause($urandom_range(1, 19));
                nbytes = 20'($urandom());
                sidx   = 6'($urandom());
                hok    = 1'($urandom());
                pick   = $urandom_range(0, 99);
                if (pick < 52) begin
                    room = sb.payload_room();
                    pay  = sb.block_payload();
                    case ($urandom_range(0, 19))
                        0:       nbytes = '0;
                        1:       ;  // full-width random request
                        2, 3:    nbytes = 20'(room + $urandom_range(1, (pay > 0) ? pay : 1));
                        4:       nbytes = 20'($urandom_range(1, (room > 0) ? room : 4096));
                        default: begin
                            if (room == 0)
                                nbytes = 20'($urandom_range(1, 4096));
                            else
                                nbytes = 20'($urandom_range(1, (room < 4 * pay) ? room
                                                                                 : 4 * pay));
                        end
                    endcase
                    issue(MODE_ALLOC, nbytes, sidx, hok, r);
                    if (r.status == ST_OK) live_handles.push_back(r.first);
                end else if (pick < 84) begin
                    // free a handle that is still live most of the time
                    if (live_handles.size() != 0 && $urandom_range(0, 9) < 8) begin
                        slot = $urandom_range(0, live_handles.size() - 1);
                        sidx = live_handles[slot];
                        hok  = 1'b1;
                        live_handles.delete(slot);
                    end
                    issue(MODE_FREE, nbytes, sidx, hok, r);
                end else if (pick < 89) begin
                    issue(MODE_REINIT, nbytes, sidx, hok, r);
                    if (r.status == ST_OK) live_handles.delete();
                end else if (pick < 91) begin
                    issue(MODE_NOP, nbytes, sidx, hok, r);
                end else begin
                    // noise: any start block, any handle flag
                    issue(MODE_FREE, nbytes, sidx, hok, r);
                end
                item_no++;
            end
        end

        // Drain: wait for every pending result, then a tail to catch strays.
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("[block_chain_allocator_top] OK");
        else
            $display("[block_chain_allocator_top] ERROR");
        $finish;
    end

endmodule
